### sv/pcm_pkg.sv
// ----------------------------------------------------------------------------
// pcm_pkg: shared definitions for the pad coordinate mapper
// Sizes, mode and status codes, register indexes and the lane result record.
// ----------------------------------------------------------------------------
package pcm_pkg;

  localparam int MAX_RANK     = 4;
  localparam int COORD_BITS   = 16;
  localparam int FIELD_BITS   = 16;
  localparam int INDEX_BITS   = 64;
  localparam int CFG_BITS     = 64;
  localparam int ADDR_BITS    = 5;
  localparam int LANE_STAGES  = COORD_BITS + 2;
  localparam int MERGE_STAGES = MAX_RANK;
  localparam int NUM_STAGES   = LANE_STAGES + MERGE_STAGES;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    MODE_CONSTANT,
    MODE_WRAP,
    MODE_EDGE,
    MODE_REFLECT
  } pad_mode_t;

  typedef enum logic [1:0] {
    STATUS_COPY,
    STATUS_PAD,
    STATUS_ERR
  } status_t;

  typedef enum logic [1:0] {
    REG_PAD_MODE,
    REG_INPUT_DIMS,
    REG_PAD_BEGINS
  } reg_index_t;

  typedef struct packed {
    coord_t mapped;
    logic   zero_dim;
    logic   out_of_range;
  } lane_result_t;

  // Axis k sits in the k-th 16-bit field counted from the top of the word.
  function automatic coord_t axis_field(logic [CFG_BITS-1:0] word, int axis);
    logic [FIELD_BITS-1:0] f;
    f = word[(CFG_BITS-1)-FIELD_BITS*axis -: FIELD_BITS];
    return f[COORD_BITS-1:0];
  endfunction

endpackage

### sv/pcm_if.sv
// ----------------------------------------------------------------------------
// pcm_if: streaming channels of the pad coordinate mapper
// One channel carries output coordinates in, the other mapped indexes out.
// ----------------------------------------------------------------------------
interface pcm_coord_if import pcm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] coord_axis0;
  logic [FIELD_BITS-1:0] coord_axis1;
  logic [FIELD_BITS-1:0] coord_axis2;
  logic [FIELD_BITS-1:0] coord_axis3;

  modport source (output valid, coord_axis0, coord_axis1, coord_axis2, coord_axis3,
                  input ready);
  modport sink (input valid, coord_axis0, coord_axis1, coord_axis2, coord_axis3,
                output ready);
endinterface

interface pcm_result_if import pcm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] source_index;
  status_t               status;

  modport source (output valid, source_index, status, input ready);
  modport sink (input valid, source_index, status, output ready);
endinterface

### sv/pcm_lane.sv
// ----------------------------------------------------------------------------
// pcm_lane: per-axis coordinate mapping pipeline
// Subtracts the leading pad, reduces the offset modulo the wrap or reflect
// period one bit per stage, then applies the padding mode.
// ----------------------------------------------------------------------------
module pcm_lane import pcm_pkg::*; (
  input  logic                   clk,
  input  logic [LANE_STAGES-1:0] adv,
  input  coord_t                 coord,
  input  coord_t                 lead_pad,
  input  coord_t                 dim,
  input  pad_mode_t              mode,
  output lane_result_t           res
);

  localparam int RW   = COORD_BITS + 1;
  localparam int LAST = COORD_BITS;

  logic [RW-1:0]        divisor;
  logic signed [RW-1:0] offset;
  coord_t               mag [0:LAST];
  logic                 neg [0:LAST];
  logic [RW-1:0]        rem [0:LAST];
  logic [RW-1:0]        folded;
  logic [RW-1:0]        reflected;
  coord_t               edge_m;
  coord_t               mapped_next;

  // The reflect period is 2*(dim-1); wrap reduces by the dimension itself.
  assign divisor = (mode == MODE_REFLECT) ? {dim - coord_t'(1), 1'b0} : {1'b0, dim};
  assign offset  = $signed({1'b0, coord}) - $signed({1'b0, lead_pad});

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      neg[0] <= offset[RW-1];
      mag[0] <= offset[RW-1] ? coord_t'(-offset) : coord_t'(offset);
      rem[0] <= '0;
    end
  end

  // Restoring remainder of the offset magnitude, most significant bit first.
  for (genvar j = 1; j <= LAST; j++) begin : g_rem
    localparam int B = COORD_BITS - j;
    logic [RW:0] trial;
    assign trial = {rem[j-1], mag[j-1][B]};
    always_ff @(posedge clk) begin
      if (adv[j]) begin
        mag[j] <= mag[j-1];
        neg[j] <= neg[j-1];
        rem[j] <= (trial >= {1'b0, divisor}) ? RW'(trial - {1'b0, divisor})
                                             : trial[RW-1:0];
      end
    end
  end

  always_comb begin
    folded    = (neg[LAST] && rem[LAST] != '0) ? divisor - rem[LAST] : rem[LAST];
    reflected = (folded >= {1'b0, dim}) ? divisor - folded : folded;
    if (neg[LAST]) begin
      edge_m = '0;
    end else if (mag[LAST] >= dim) begin
      edge_m = dim - coord_t'(1);
    end else begin
      edge_m = mag[LAST];
    end
    case (mode)
      MODE_WRAP:    mapped_next = folded[COORD_BITS-1:0];
      MODE_EDGE:    mapped_next = edge_m;
      MODE_REFLECT: mapped_next = (dim == coord_t'(1)) ? '0 : reflected[COORD_BITS-1:0];
      default:      mapped_next = mag[LAST];
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[LAST+1]) begin
      res.mapped       <= mapped_next;
      res.zero_dim     <= (dim == '0);
      res.out_of_range <= neg[LAST] || (mag[LAST] >= dim);
    end
  end

endmodule

### sv/pcm_merge.sv
// ----------------------------------------------------------------------------
// pcm_merge: combines the lane results into status and linear index
// Status is resolved in the first stage; the row-major index is built by
// Horner steps, one multiply-add per stage.
// ----------------------------------------------------------------------------
module pcm_merge import pcm_pkg::*; (
  input  logic                    clk,
  input  logic [MERGE_STAGES-1:0] adv,
  input  lane_result_t            lanes [MAX_RANK],
  input  coord_t                  dims [MAX_RANK],
  input  pad_mode_t               mode,
  output logic [INDEX_BITS-1:0]   source_index,
  output status_t                 status
);

  localparam int LAST = MERGE_STAGES - 1;

  logic [INDEX_BITS-1:0] acc  [0:LAST];
  status_t               st   [0:LAST];
  coord_t                hold [0:LAST][MAX_RANK];
  logic                  any_zero;
  logic                  any_oob;
  status_t               st_next;

  always_comb begin
    any_zero = 1'b0;
    any_oob  = 1'b0;
    for (int k = 0; k < MAX_RANK; k++) begin
      any_zero = any_zero | lanes[k].zero_dim;
      any_oob  = any_oob | lanes[k].out_of_range;
    end
    if (mode != MODE_CONSTANT && any_zero) begin
      st_next = STATUS_ERR;
    end else if (mode == MODE_CONSTANT && any_oob) begin
      st_next = STATUS_PAD;
    end else begin
      st_next = STATUS_COPY;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      st[0]  <= st_next;
      acc[0] <= INDEX_BITS'(lanes[0].mapped);
      for (int k = 0; k < MAX_RANK; k++) begin
        hold[0][k] <= lanes[k].mapped;
      end
    end
  end

  for (genvar s = 1; s <= LAST; s++) begin : g_horner
    always_ff @(posedge clk) begin
      if (adv[s]) begin
        st[s]   <= st[s-1];
        hold[s] <= hold[s-1];
        acc[s]  <= INDEX_BITS'(acc[s-1] * INDEX_BITS'(dims[s]))
                   + INDEX_BITS'(hold[s-1][s]);
      end
    end
  end

  assign status       = st[LAST];
  assign source_index = (st[LAST] == STATUS_COPY) ? acc[LAST] : '0;

endmodule

### sv/pad_coordinate_mapper_core.sv
// ----------------------------------------------------------------------------
// pad_coordinate_mapper_core: padding address generator, four axes in parallel
// Maps each output coordinate to a source index or a pad/error status.
// ----------------------------------------------------------------------------
// Usage: each transaction on the coord channel carries one output coordinate
// (axis 0 outermost). Each transaction on the result channel returns the
// row-major source index and a status (copy, constant pad, zero-dimension
// error), one result per coordinate, in order.
// Configuration (mode, packed dimensions, packed leading pads) is written over
// the APB port at byte addresses 0, 8 and 16. The user must write it only while
// no transaction is in flight; the block itself does not enforce this.
// The pipeline has 22 stages: one setup stage, sixteen remainder stages (one
// quotient bit each in every lane), one mode-fix stage and four merge stages
// (status, then three multiply-adds). Every stage holds one transaction.
// Throughput is one transaction per cycle while the receiver is ready.
// Reset clears all pipeline valid bits and restores the configuration to
// constant mode, unit dimensions and zero pads.
// When the receiver stalls, stages fill from the output backward; coord.ready
// stays high while any stage is empty, so bubbles are squeezed out.
// ----------------------------------------------------------------------------
module pad_coordinate_mapper_core import pcm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  pcm_coord_if.sink             coord,
  pcm_result_if.source          result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_BITS-1:0]  paddr,
  input  logic [CFG_BITS-1:0]   pwdata,
  output logic [CFG_BITS-1:0]   prdata,
  output logic                  pready
);

  // Configuration registers.
  pad_mode_t           pad_mode;
  logic [CFG_BITS-1:0] input_dims;
  logic [CFG_BITS-1:0] pad_begins;
  reg_index_t          reg_sel;

  assign reg_sel = reg_index_t'(paddr[ADDR_BITS-1:3]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_mode   <= MODE_CONSTANT;
      input_dims <= 64'h0001_0001_0001_0001;
      pad_begins <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_PAD_MODE:   pad_mode   <= pad_mode_t'(pwdata[1:0]);
        REG_INPUT_DIMS: input_dims <= pwdata;
        REG_PAD_BEGINS: pad_begins <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PAD_MODE:   prdata = CFG_BITS'(pad_mode);
      REG_INPUT_DIMS: prdata = input_dims;
      REG_PAD_BEGINS: prdata = pad_begins;
      default:        prdata = '0;
    endcase
  end

  // Pipeline flow control: a stage advances when it is empty or when the
  // stage after it advances. The output stage drains on result.ready.
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES:0]   adv;

  assign adv[NUM_STAGES] = result.ready;
  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_adv
    assign adv[s] = !vld[s] || adv[s+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= coord.valid;
      end
      for (int s = 1; s < NUM_STAGES; s++) begin
        if (adv[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  assign coord.ready  = adv[0];
  assign result.valid = vld[NUM_STAGES-1];

  // Per-axis operands.
  coord_t       coord_in [4];
  coord_t       dims     [MAX_RANK];
  coord_t       pads     [MAX_RANK];
  lane_result_t lanes    [MAX_RANK];

  assign coord_in[0] = coord.coord_axis0[COORD_BITS-1:0];
  assign coord_in[1] = coord.coord_axis1[COORD_BITS-1:0];
  assign coord_in[2] = coord.coord_axis2[COORD_BITS-1:0];
  assign coord_in[3] = coord.coord_axis3[COORD_BITS-1:0];

  for (genvar k = 0; k < MAX_RANK; k++) begin : g_lane
    assign dims[k] = axis_field(input_dims, k);
    assign pads[k] = axis_field(pad_begins, k);

    pcm_lane u_lane (
      .clk      (clk),
      .adv      (adv[LANE_STAGES-1:0]),
      .coord    (coord_in[k]),
      .lead_pad (pads[k]),
      .dim      (dims[k]),
      .mode     (pad_mode),
      .res      (lanes[k])
    );
  end

  pcm_merge u_merge (
    .clk          (clk),
    .adv          (adv[NUM_STAGES-1:LANE_STAGES]),
    .lanes        (lanes),
    .dims         (dims),
    .mode         (pad_mode),
    .source_index (result.source_index),
    .status       (result.status)
  );

  // A result that is not a copy never carries an index.
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status != STATUS_COPY |-> result.source_index == '0)
    else $error("non-copy result carries a nonzero index");

  // An empty output stage means the whole pipeline can move.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> coord.ready)
    else $error("input stalled while output stage is empty");

  // Pad status only arises in constant mode.
  a_pad_only_constant: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status == STATUS_PAD |-> pad_mode == MODE_CONSTANT)
    else $error("pad status outside constant mode");

endmodule
